// ----- rtl/core/u8s_pkg.sv -----
// Shared types, codes and constants of the UTF-8 text sniffer.
// No dependencies; the scan logic, the top level and the testbench import it.
package u8s_pkg;

	localparam int unsigned MagicLen = 5;

	typedef enum logic [1:0] {
		VERDICT_TEXT    = 2'd0,
		VERDICT_NUL     = 2'd1,
		VERDICT_INVALID = 2'd2
	} verdict_t;

	// Constraint on the byte after a lead byte
	typedef enum logic [2:0] {
		LC_NONE = 3'd0,
		LC_E0   = 3'd1,
		LC_ED   = 3'd2,
		LC_F0   = 3'd3,
		LC_F4   = 3'd4
	} lead_class_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last;
	} sample_t;

	typedef struct packed {
		logic       pdf_magic;
		logic [1:0] content_verdict;
	} report_t;

	typedef struct packed {
		logic [2:0]  magic_pos;
		logic        magic_match;
		logic [1:0]  bytes_rem;
		lead_class_t lead_class;
		logic        pending_err;
		logic        invalid_seen;
		logic        nul_seen;
	} scan_state_t;

	localparam scan_state_t ScanReset = '{
		magic_pos:    3'd0,
		magic_match:  1'b1,
		bytes_rem:    2'd0,
		lead_class:   LC_NONE,
		pending_err:  1'b0,
		invalid_seen: 1'b0,
		nul_seen:     1'b0
	};

	// Expected byte of "%PDF-" at a given position
	function automatic logic [7:0] magic_char(input logic [2:0] pos);
		logic [7:0] c;
		case (pos)
			3'd0: c = 8'h25;
			3'd1: c = 8'h50;
			3'd2: c = 8'h44;
			3'd3: c = 8'h46;
			3'd4: c = 8'h2D;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// ----- rtl/core/u8s_stream_if.sv -----
// Valid/ready stream channel with a typed payload.
// Depends on nothing; payload types come from u8s_pkg at instantiation.
interface u8s_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/core/u8s_scan.sv -----
// Next-state and result logic of the sniffer for one sample byte.
// Depends on u8s_pkg.
module u8s_scan (
	input  u8s_pkg::scan_state_t cur,
	input  logic [7:0]           data_byte,
	input  logic                 last,
	output u8s_pkg::scan_state_t nxt,
	output u8s_pkg::report_t     result
);
	import u8s_pkg::*;

	scan_state_t upd;
	logic        bad;
	logic [1:0]  rem_dec;

	always_comb begin
		upd     = cur;
		bad     = 1'b0;
		rem_dec = cur.bytes_rem - 2'd1;

		// compare the leading bytes against the PDF signature
		if (cur.magic_pos < 3'(MagicLen)) begin
			if (data_byte != magic_char(cur.magic_pos)) begin
				upd.magic_match = 1'b0;
			end
			upd.magic_pos = cur.magic_pos + 3'd1;
		end
		if (data_byte == 8'h00) begin
			upd.nul_seen = 1'b1;
		end

		if (cur.bytes_rem == 2'd0) begin
			// lead byte
			upd.pending_err = 1'b0;
			upd.lead_class  = LC_NONE;
			if (data_byte < 8'h80) begin
				upd.bytes_rem = 2'd0;
			end else if (data_byte >= 8'hC2 && data_byte <= 8'hDF) begin
				upd.bytes_rem = 2'd1;
			end else if (data_byte >= 8'hE0 && data_byte <= 8'hEF) begin
				upd.bytes_rem = 2'd2;
				if (data_byte == 8'hE0) upd.lead_class = LC_E0;
				else if (data_byte == 8'hED) upd.lead_class = LC_ED;
			end else if (data_byte >= 8'hF0 && data_byte <= 8'hF4) begin
				upd.bytes_rem = 2'd3;
				if (data_byte == 8'hF0) upd.lead_class = LC_F0;
				else if (data_byte == 8'hF4) upd.lead_class = LC_F4;
			end else begin
				upd.invalid_seen = 1'b1;
			end
		end else begin
			// continuation byte
			bad = (data_byte & 8'hC0) != 8'h80;
			case (cur.lead_class)
				LC_E0:   bad = bad || (data_byte < 8'hA0);
				LC_ED:   bad = bad || (data_byte >= 8'hA0);
				LC_F0:   bad = bad || (data_byte < 8'h90);
				LC_F4:   bad = bad || (data_byte >= 8'h90);
				default: bad = bad;
			endcase
			upd.lead_class = LC_NONE;
			if (bad) upd.pending_err = 1'b1;
			upd.bytes_rem = rem_dec;
			if (rem_dec == 2'd0) begin
				if (upd.pending_err) upd.invalid_seen = 1'b1;
				upd.pending_err = 1'b0;
			end
		end
	end

	always_comb begin
		result.pdf_magic = upd.magic_match && (upd.magic_pos == 3'(MagicLen));
		if (upd.nul_seen) begin
			result.content_verdict = VERDICT_NUL;
		end else if (upd.invalid_seen) begin
			result.content_verdict = VERDICT_INVALID;
		end else begin
			result.content_verdict = VERDICT_TEXT;
		end
		nxt = last ? ScanReset : upd;
	end

endmodule

// ----- rtl/core/utf8_text_sniffer_unit.sv -----
// UTF-8 text sniffer: top level with input register, scan state and result register.
// Depends on u8s_pkg, u8s_stream_if and u8s_scan.
//
// The block takes the leading bytes of a file, one byte per transfer on the
// sample channel, with last set on the final byte. For each sample it returns
// one transfer on the report channel: pdf_magic says whether the sample began
// with "%PDF-", and content_verdict gives 0 for valid UTF-8 text, 1 if any NUL
// byte was seen (this wins over an invalid encoding), 2 for invalid UTF-8. A
// multibyte sequence cut off by the end of the sample is not held against it.
// The block sustains one byte per clock: a byte lands in the input register,
// and the scan state and the result register update from it as it advances,
// so the report is loaded into the result register as the final byte leaves
// the input register, and a ready receiver takes it from there.
// The rate is set by the single scan state update per cycle; bytes without
// last never wait, and a final byte waits only while an earlier report is
// still held in the result register. The scan state clears after every sample,
// so samples follow one another with no gap. Limiting the sample length
// is left to the feeder.
module utf8_text_sniffer_unit (
	input  logic         clk,
	input  logic         arst_n,
	u8s_stream_if.sink   sample,
	u8s_stream_if.source report
);
	import u8s_pkg::*;

	logic        valid_s1;
	sample_t     sample_s1;
	scan_state_t state_q;
	scan_state_t state_d;
	report_t     result;
	report_t     report_q;
	logic        report_valid_q;
	logic        advance;

	// Advance the held byte unless it ends a sample and the last report is
	// still waiting to be taken.
	assign advance      = valid_s1 && (!sample_s1.last || !report_valid_q || report.ready);
	assign sample.ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			sample_s1 <= sample.payload;
		end
	end

	u8s_scan u_scan (
		.cur       (state_q),
		.data_byte (sample_s1.data_byte),
		.last      (sample_s1.last),
		.nxt       (state_d),
		.result    (result)
	);

	// Scan state: advance once per byte; the scan logic clears it on last.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ScanReset;
		end else if (advance) begin
			state_q <= state_d;
		end
	end

	// Result register: load on a final byte, drop once transferred.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_valid_q <= 1'b0;
		end else if (advance && sample_s1.last) begin
			report_valid_q <= 1'b1;
		end else if (report.ready) begin
			report_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && sample_s1.last) begin
			report_q <= result;
		end
	end

	assign report.valid   = report_valid_q;
	assign report.payload = report_q;

	// No second-byte rule stays armed once a sequence is closed.
	a_class_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.bytes_rem == 2'd0 |-> state_q.lead_class == LC_NONE)
		else $error("lead class armed outside a sequence");

	// A pending error lives only inside an open sequence.
	a_pending_open: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.pending_err |-> state_q.bytes_rem != 2'd0)
		else $error("pending error outside a sequence");

	// The signature position saturates at its length.
	a_magic_sat: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.magic_pos <= 3'(MagicLen))
		else $error("signature position past its length");

	// A final byte always leaves the scan state cleared.
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		advance && sample_s1.last |=> state_q == ScanReset)
		else $error("scan state not cleared after final byte");

	// A final byte that cannot advance holds in the input register.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && sample_s1.last && !advance |=> valid_s1 && sample_s1.last)
		else $error("stalled final byte lost");

endmodule

// ----- verif/tb_utf8_text_sniffer_unit.sv -----
// Testbench for utf8_text_sniffer_unit: directed and random byte samples, with idle and stall.
// Depends on u8s_pkg, u8s_stream_if and the utf8_text_sniffer_unit RTL; no files or arguments.
module tb_utf8_text_sniffer_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import u8s_pkg::*;

	localparam int unsigned WatchdogLimit = 3000;
	localparam int unsigned ReportLatency = 8;
	localparam int unsigned LongStall     = 400;

	// Signature bytes, kept separate from the package helper
	localparam logic [7:0] PDF_SIG [MagicLen] = '{8'h25, 8'h50, 8'h44, 8'h46, 8'h2D};

	logic clk = 1'b0;
	logic arst_n;

	u8s_stream_if #(.payload_t(sample_t)) sample_if ();
	u8s_stream_if #(.payload_t(report_t)) report_if ();

	utf8_text_sniffer_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_if),
		.report (report_if)
	);

	always #4 clk = ~clk;

	// Sniffer state as the testbench tracks it
	int unsigned magic_seen;
	bit          magic_ok;
	logic [1:0]  cont_left;
	lead_class_t second_rule;
	bit          seq_bad;
	bit          bad_seen;
	bit          nul_hit;

	report_t     expected_reports[$];
	logic [7:0]  sample_buf[$];
	int unsigned items_sent;
	int unsigned error_count;
	bit          tx_idle_on;
	bit          rx_idle_on;
	int unsigned stall_left;

	function automatic void clear_sniffer();
		magic_seen  = 0;
		magic_ok    = 1'b1;
		cont_left   = 2'd0;
		second_rule = LC_NONE;
		seq_bad     = 1'b0;
		bad_seen    = 1'b0;
		nul_hit     = 1'b0;
	endfunction

	// Advance the tracked state by one byte; on the final byte queue the report
	function automatic void sniff_byte(input logic [7:0] b, input logic fin);
		bit      bad;
		report_t rep;
		if (magic_seen < MagicLen) begin
			if (b != PDF_SIG[magic_seen]) magic_ok = 1'b0;
			magic_seen++;
		end
		if (b == 8'h00) nul_hit = 1'b1;

		if (cont_left == 2'd0) begin
			// Expect a lead byte
			seq_bad     = 1'b0;
			second_rule = LC_NONE;
			if (b < 8'h80) begin
				// plain ASCII
			end else if (b >= 8'hC2 && b <= 8'hDF) begin
				cont_left = 2'd1;
			end else if (b >= 8'hE0 && b <= 8'hEF) begin
				cont_left = 2'd2;
				if (b == 8'hE0) second_rule = LC_E0;
				else if (b == 8'hED) second_rule = LC_ED;
			end else if (b >= 8'hF0 && b <= 8'hF4) begin
				cont_left = 2'd3;
				if (b == 8'hF0) second_rule = LC_F0;
				else if (b == 8'hF4) second_rule = LC_F4;
			end else begin
				bad_seen = 1'b1;
			end
		end else begin
			// Continuation byte, with the tighter second-byte ranges
			bad = (b[7:6] != 2'b10);
			case (second_rule)
				LC_E0: bad = bad || (b < 8'hA0);
				LC_ED: bad = bad || (b >= 8'hA0);
				LC_F0: bad = bad || (b < 8'h90);
				LC_F4: bad = bad || (b >= 8'h90);
				default: ;
			endcase
			second_rule = LC_NONE;
			if (bad) seq_bad = 1'b1;
			cont_left = cont_left - 2'd1;
			// An error only counts once the sequence is complete
			if (cont_left == 2'd0) begin
				if (seq_bad) bad_seen = 1'b1;
				seq_bad = 1'b0;
			end
		end

		if (fin) begin
			rep.pdf_magic = magic_ok && (magic_seen == MagicLen);
			if (nul_hit) rep.content_verdict = VERDICT_NUL;
			else if (bad_seen) rep.content_verdict = VERDICT_INVALID;
			else rep.content_verdict = VERDICT_TEXT;
			expected_reports.push_back(rep);
			clear_sniffer();
		end
	endfunction

	function automatic void check_report(input report_t got);
		report_t want;
		if (expected_reports.size() == 0) begin
			$display("%0t: report with nothing expected: pdf_magic %0b verdict %0d",
				$time, got.pdf_magic, got.content_verdict);
			error_count++;
			return;
		end
		want = expected_reports.pop_front();
		if (got.pdf_magic !== want.pdf_magic) begin
			$display("%0t: pdf_magic mismatch: expected %0b actual %0b",
				$time, want.pdf_magic, got.pdf_magic);
			error_count++;
		end
		if (got.content_verdict !== want.content_verdict) begin
			$display("%0t: content_verdict mismatch: expected %0d actual %0d",
				$time, want.content_verdict, got.content_verdict);
			error_count++;
		end
	endfunction

	// Observe both channels at each rising edge. Input transfers are tracked
	// before report transfers so the expectation queue is always current.
	always @(posedge clk) begin
		if (arst_n && sample_if.valid && sample_if.ready)
			sniff_byte(sample_if.payload.data_byte, sample_if.payload.last);
		if (arst_n && report_if.valid && report_if.ready)
			check_report(report_if.payload);
	end

	// Report receiver: a requested hold-off wins, then random idling, else always ready
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			report_if.ready <= 1'b0;
		end else if (rx_idle_on) begin
			report_if.ready <= ($urandom_range(0, 99) >= 35);
		end else begin
			report_if.ready <= 1'b1;
		end
	end

	// Watchdog: end the run when nothing transfers on either channel for too long
	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < WatchdogLimit) begin
			@(posedge clk);
			if ((sample_if.valid && sample_if.ready) || (report_if.valid && report_if.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no transfer for %0d cycles", $time, WatchdogLimit);
		$display("== FAIL ==");
		$finish;
	end

	// Offer one byte, with a random gap first when the sender idles, and hold
	// it until the transfer. Valid stays high into the next call when no gap
	// follows, so back-to-back bytes never see valid drop.
	task automatic send_byte(input logic [7:0] b, input logic fin);
		int unsigned gap;
		gap = 0;
		if (tx_idle_on)
			while ($urandom_range(0, 99) < 35) gap++;
		if (gap != 0) begin
			sample_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_if.valid   <= 1'b1;
		sample_if.payload <= sample_t'{data_byte: b, last: fin};
		@(posedge clk);
		while (!sample_if.ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic send_sample();
		foreach (sample_buf[i])
			send_byte(sample_buf[i], i == sample_buf.size() - 1);
	endtask

	// Drop valid and hold until every queued report has come back
	task automatic wait_for_reports();
		sample_if.valid <= 1'b0;
		@(posedge clk);
		while (expected_reports.size() != 0) @(posedge clk);
		repeat (ReportLatency) @(posedge clk);
	endtask

	// A legal second byte for the given lead
	function automatic logic [7:0] second_byte(input logic [7:0] lead);
		case (lead)
			8'hE0: return 8'($urandom_range(8'hA0, 8'hBF));
			8'hED: return 8'($urandom_range(8'h80, 8'h9F));
			8'hF0: return 8'($urandom_range(8'h90, 8'hBF));
			8'hF4: return 8'($urandom_range(8'h80, 8'h8F));
			default: return 8'($urandom_range(8'h80, 8'hBF));
		endcase
	endfunction

	function automatic logic [7:0] cont_byte();
		return 8'($urandom_range(8'h80, 8'hBF));
	endfunction

	// Fill sample_buf with a sample: mostly well-formed UTF-8 with random
	// content, some bad leads, broken sequences, NULs, signatures and cut-offs.
	task automatic build_random_sample(input int unsigned max_units);
		int unsigned units, kind, cut, seq_len;
		logic [7:0]  lead;
		sample_buf.delete();
		if ($urandom_range(0, 7) == 0) begin
			foreach (PDF_SIG[i]) sample_buf.push_back(PDF_SIG[i]);
			if ($urandom_range(0, 3) == 0)
				sample_buf[$urandom_range(0, MagicLen - 1)] = 8'($urandom_range(0, 255));
		end
		units = $urandom_range(0, max_units);
		repeat (units) begin
			kind = $urandom_range(0, 99);
			if (kind < 38) begin
				sample_buf.push_back(8'($urandom_range(1, 127)));
			end else if (kind < 52) begin
				sample_buf.push_back(8'($urandom_range(8'hC2, 8'hDF)));
				sample_buf.push_back(cont_byte());
			end else if (kind < 66) begin
				if ($urandom_range(0, 1)) lead = $urandom_range(0, 1) ? 8'hE0 : 8'hED;
				else lead = 8'($urandom_range(8'hE0, 8'hEF));
				sample_buf.push_back(lead);
				sample_buf.push_back(second_byte(lead));
				sample_buf.push_back(cont_byte());
			end else if (kind < 78) begin
				if ($urandom_range(0, 1)) lead = $urandom_range(0, 1) ? 8'hF0 : 8'hF4;
				else lead = 8'($urandom_range(8'hF0, 8'hF4));
				sample_buf.push_back(lead);
				sample_buf.push_back(second_byte(lead));
				sample_buf.push_back(cont_byte());
				sample_buf.push_back(cont_byte());
			end else if (kind < 86) begin
				// Byte that can never start a sequence
				if ($urandom_range(0, 1)) sample_buf.push_back(8'($urandom_range(8'h80, 8'hC1)));
				else sample_buf.push_back(8'($urandom_range(8'hF5, 8'hFF)));
			end else if (kind < 96) begin
				// Valid lead, then bytes of any value
				case ($urandom_range(0, 4))
					0: lead = 8'hE0;
					1: lead = 8'hED;
					2: lead = 8'hF0;
					3: lead = 8'hF4;
					default: lead = 8'($urandom_range(8'hC2, 8'hF4));
				endcase
				seq_len = (lead < 8'hE0) ? 2 : ((lead < 8'hF0) ? 3 : 4);
				sample_buf.push_back(lead);
				repeat (seq_len - 1) sample_buf.push_back(8'($urandom_range(0, 255)));
			end else begin
				sample_buf.push_back(8'h00);
			end
		end
		if (sample_buf.size() == 0) sample_buf.push_back(8'($urandom_range(0, 255)));
		// Cut the sample short, often inside a sequence
		if (sample_buf.size() > 1 && $urandom_range(0, 4) == 0) begin
			cut = $urandom_range(1, sample_buf.size() - 1);
			while (sample_buf.size() > cut) void'(sample_buf.pop_back());
		end
	endtask

	// Signature, short sample, NUL, bad leads, second-byte limits, cut-off sequence
	task automatic test_directed();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		sample_buf = '{8'h25, 8'h50, 8'h44, 8'h46, 8'h2D};  // exact signature, text
		send_sample();
		sample_buf = '{8'h25, 8'h50, 8'h44};                // shorter than the signature
		send_sample();
		sample_buf = '{8'h00};                              // NUL only
		send_sample();
		sample_buf = '{8'hFF};                              // bad lead on the final byte
		send_sample();
		sample_buf = '{8'hC3, 8'h28};                       // non-continuation completes the sequence
		send_sample();
		sample_buf = '{8'hE0, 8'h80, 8'h80};                // overlong after E0
		send_sample();
		sample_buf = '{8'hED, 8'hA0};                       // surrogate, cut off: ignored
		send_sample();
		sample_buf = '{8'hF4, 8'h8F, 8'hBF, 8'hBF};         // highest code point
		send_sample();
		sample_buf = '{8'h00, 8'hFF};                       // NUL wins over invalid
		send_sample();
		sample_buf = '{8'h7F};                              // top of ASCII
		send_sample();
	endtask

	task automatic test_random_samples(input int unsigned item_budget);
		int unsigned target;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		target = items_sent + item_budget;
		while (items_sent < target) begin
			build_random_sample(($urandom_range(0, 19) == 0) ? 30 : 8);
			send_sample();
		end
	endtask

	// Full-rate stretch: neither side idles
	task automatic test_steady_stream(input int unsigned item_budget);
		int unsigned target;
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		target = items_sent + item_budget;
		while (items_sent < target) begin
			build_random_sample(6);
			send_sample();
		end
	endtask

	// Hold the report side off while short samples keep coming, so the block
	// fills and stalls its input; then pause until every report is back.
	task automatic test_report_backpressure();
		tx_idle_on = 1'b0;
		stall_left = LongStall;
		repeat (30) begin
			build_random_sample(1);
			send_sample();
		end
		wait_for_reports();
	endtask

	initial begin
		arst_n            = 1'b0;
		sample_if.valid   = 1'b0;
		sample_if.payload = '0;
		report_if.ready   = 1'b0;
		items_sent        = 0;
		error_count       = 0;
		tx_idle_on        = 1'b0;
		rx_idle_on        = 1'b0;
		stall_left        = 0;
		clear_sniffer();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random_samples(850);
		test_steady_stream(400);
		test_report_backpressure();
		test_random_samples(550);
		wait_for_reports();

		if (error_count == 0 && expected_reports.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
